### rtl/core/rcbp_pkg.sv
// ----------------------------------------------------------------------------
// rcbp_pkg
// Shared types and constants of the Rice encoder and byte packer.
// ----------------------------------------------------------------------------
package rcbp_pkg;

  localparam int VALUE_FIELD_W = 32;
  localparam int VALUE_WIDTH   = 32;
  localparam logic [VALUE_FIELD_W-1:0] VALUE_MASK =
    (VALUE_WIDTH >= VALUE_FIELD_W) ? '1 : VALUE_FIELD_W'((64'd1 << VALUE_WIDTH) - 64'd1);

  localparam int DEF_MAX_QUOTIENT = 255;
  localparam int QUEUE_DEPTH      = 2;

  localparam int          K_W     = 5;
  localparam logic [4:0]  K_RESET = 5'd6;
  localparam logic [4:0]  K_MIN   = 5'd1;
  localparam logic [4:0]  K_MAX   = 5'd16;

  localparam int TAIL_W = 17;
  localparam int TLEN_W = 5;

  localparam logic OP_ENCODE  = 1'b0;
  localparam logic OP_FLUSH   = 1'b1;
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [1:0] {
    CMD_ENCODE,
    CMD_FLUSH,
    CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [TAIL_W-1:0]   tail;
    logic [TLEN_W-1:0]   tlen;
  } cmd_t;

endpackage

### rtl/core/rcbp_front.sv
// ----------------------------------------------------------------------------
// rcbp_front
// Holds the divisor exponent and turns each input beat into a command.
// ----------------------------------------------------------------------------
module rcbp_front #(
  parameter int MAX_QUOTIENT = rcbp_pkg::DEF_MAX_QUOTIENT,
  parameter int QW           = $clog2(MAX_QUOTIENT + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcbp_pkg::K_W-1:0]           cfg_data,
  input  logic                               in_op,
  input  logic [rcbp_pkg::VALUE_FIELD_W-1:0] in_value,
  output rcbp_pkg::cmd_t                     cmd,
  output logic [QW-1:0]                      cmd_quot
);

  logic [rcbp_pkg::K_W-1:0]           k_r;
  logic [rcbp_pkg::K_W-1:0]           k_nxt;
  logic [rcbp_pkg::K_W-1:0]           k_eff;
  logic [rcbp_pkg::VALUE_FIELD_W-1:0] value_m;
  logic [rcbp_pkg::VALUE_FIELD_W-1:0] quot;
  logic [rcbp_pkg::VALUE_FIELD_W-1:0] rem_mask;

  assign cfg_ready = 1'b1;
  assign k_nxt     = cfg_valid ? cfg_data : k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= rcbp_pkg::K_RESET;
    end else begin
      k_r <= k_nxt;
    end
  end

  always_comb begin
    if (k_r < rcbp_pkg::K_MIN) begin
      k_eff = rcbp_pkg::K_MIN;
    end else if (k_r > rcbp_pkg::K_MAX) begin
      k_eff = rcbp_pkg::K_MAX;
    end else begin
      k_eff = k_r;
    end
  end

  assign value_m  = in_value & rcbp_pkg::VALUE_MASK;
  assign quot     = value_m >> k_eff;
  assign rem_mask = (rcbp_pkg::VALUE_FIELD_W'(1) << k_eff) - rcbp_pkg::VALUE_FIELD_W'(1);
  assign cmd_quot = QW'(quot);

  always_comb begin
    cmd.tail = rcbp_pkg::TAIL_W'(value_m & rem_mask);
    cmd.tlen = k_eff + rcbp_pkg::TLEN_W'(1);
    if (in_op == rcbp_pkg::OP_FLUSH) begin
      cmd.kind = rcbp_pkg::CMD_FLUSH;
    end else if (quot > rcbp_pkg::VALUE_FIELD_W'(MAX_QUOTIENT)) begin
      cmd.kind = rcbp_pkg::CMD_ERROR;
    end else begin
      cmd.kind = rcbp_pkg::CMD_ENCODE;
    end
  end

endmodule

### rtl/core/rcbp_queue.sv
// ----------------------------------------------------------------------------
// rcbp_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module rcbp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rcbp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW-1:0]    rd_ptr_nxt;
  logic [LW-1:0]    level_r;
  logic [LW-1:0]    level_nxt;

  assign full  = (level_r == LW'(DEPTH));
  assign empty = (level_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      level_nxt = level_r + LW'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/rcbp_back.sv
// ----------------------------------------------------------------------------
// rcbp_back
// Writes the code bits of each command into the pending byte, up to a whole
// byte per cycle when the output register is free, and holds that register.
// ----------------------------------------------------------------------------
module rcbp_back #(
  parameter int QW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  rcbp_pkg::cmd_t cmd,
  input  logic [QW-1:0]  cmd_quot,
  output logic           cmd_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tuser,
  output logic           out_tlast
);

  localparam int SW = ((QW > rcbp_pkg::TLEN_W) ? QW : rcbp_pkg::TLEN_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ONES,
    S_TAIL
  } state_t;

  state_t                      state_r,   state_nxt;
  logic [QW-1:0]               q_left_r,  q_left_nxt;
  logic [rcbp_pkg::TAIL_W-1:0] tail_r,    tail_nxt;
  logic [rcbp_pkg::TLEN_W-1:0] t_left_r,  t_left_nxt;
  logic [7:0]                  pend_r,    pend_nxt;
  logic [2:0]                  cnt_r,     cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r,  out_byte_nxt;
  logic                        out_kind_r,  out_kind_nxt;
  logic                        out_last_r,  out_last_nxt;

  logic                        out_free;
  logic [3:0]                  avail;
  logic [3:0]                  n;
  logic [7:0]                  nmask;
  logic [7:0]                  chunk;
  logic [15:0]                 acc;
  logic [3:0]                  sum_cnt;
  logic [QW-1:0]               q_after;
  logic [rcbp_pkg::TLEN_W-1:0] t_after;
  logic [SW-1:0]               rest;
  logic                        chunk_last;

  assign out_free = !out_valid_r || out_tready;
  assign avail    = 4'd8 - {1'b0, cnt_r};

  always_comb begin
    if (state_r == S_ONES) begin
      n = (SW'(q_left_r) < SW'(avail)) ? 4'(q_left_r) : avail;
    end else begin
      n = (SW'(t_left_r) < SW'(avail)) ? 4'(t_left_r) : avail;
    end
  end

  assign nmask = 8'((9'd1 << n) - 9'd1);

  always_comb begin
    if (state_r == S_ONES) begin
      chunk   = nmask;
      q_after = q_left_r - QW'(n);
      t_after = t_left_r;
    end else begin
      chunk   = 8'(tail_r >> (t_left_r - rcbp_pkg::TLEN_W'(n))) & nmask;
      q_after = q_left_r;
      t_after = t_left_r - rcbp_pkg::TLEN_W'(n);
    end
  end

  assign acc        = ({8'b0, pend_r} << n) | {8'b0, chunk};
  assign sum_cnt    = {1'b0, cnt_r} + n;
  assign rest       = SW'(q_after) + SW'(t_after);
  assign chunk_last = (rest < SW'(8));

  always_comb begin
    state_nxt     = state_r;
    q_left_nxt    = q_left_r;
    tail_nxt      = tail_r;
    t_left_nxt    = t_left_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    cmd_pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            rcbp_pkg::CMD_ERROR: begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = 8'd0;
              out_kind_nxt  = rcbp_pkg::KIND_ERROR;
              out_last_nxt  = 1'b1;
            end
            rcbp_pkg::CMD_FLUSH: begin
              if (cnt_r != 3'd0) begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = 8'(pend_r << (4'd8 - {1'b0, cnt_r}));
                out_kind_nxt  = rcbp_pkg::KIND_BYTE;
                out_last_nxt  = 1'b1;
              end
              pend_nxt = 8'd0;
              cnt_nxt  = 3'd0;
            end
            default: begin
              q_left_nxt = cmd_quot;
              tail_nxt   = cmd.tail;
              t_left_nxt = cmd.tlen;
              state_nxt  = (cmd_quot == '0) ? S_TAIL : S_ONES;
            end
          endcase
        end
      end
      S_ONES, S_TAIL: begin
        if (out_free) begin
          if (sum_cnt == 4'd8) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = acc[7:0];
            out_kind_nxt  = rcbp_pkg::KIND_BYTE;
            out_last_nxt  = chunk_last;
            pend_nxt      = 8'd0;
            cnt_nxt       = 3'd0;
          end else begin
            pend_nxt = acc[7:0];
            cnt_nxt  = sum_cnt[2:0];
          end
          q_left_nxt = q_after;
          t_left_nxt = t_after;
          if (state_r == S_ONES) begin
            state_nxt = (q_after == '0) ? S_TAIL : S_ONES;
          end else begin
            state_nxt = (t_after == '0) ? S_IDLE : S_TAIL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 8'd0;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_left_r   <= q_left_nxt;
    tail_r     <= tail_nxt;
    t_left_r   <= t_left_nxt;
    out_byte_r <= out_byte_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/core/rice_encoder_byte_packer_unit.sv
// ----------------------------------------------------------------------------
// rice_encoder_byte_packer_unit
// Golomb-Rice encoder with a power-of-two divisor and MSB-first byte packing.
//
//   Channel  Direction  Beat contents
//   in_      slave      tuser = op, tdata = value
//   out_     master     tuser = kind, tdata = packed byte, tlast = last
//   cfg_     slave      cfg_data = log2_divisor
//
// The back end takes an encode beat, then writes q unary ones when q is nonzero,
// then the k + 1 bits of the terminating zero and the remainder, after the p
// bits pending; flush and error beats end when taken. Every back end step waits on
// a full output register. Reset is synchronous, clears the queue, the pending
// bits and the output register, and sets k to 6. A two-entry queue keeps the
// input taking beats while the back waits.
// ----------------------------------------------------------------------------
module rice_encoder_byte_packer_unit #(
  parameter int MAX_QUOTIENT = rcbp_pkg::DEF_MAX_QUOTIENT,
  parameter int QUEUE_DEPTH  = rcbp_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcbp_pkg::K_W-1:0]           cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rcbp_pkg::VALUE_FIELD_W-1:0] in_tdata,   // [31:0] value
  input  logic                               in_tuser,   // [0] op
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] out_byte
  output logic                               out_tuser,  // [0] kind
  output logic                               out_tlast
);

  localparam int QW = $clog2(MAX_QUOTIENT + 1);
  localparam int CW = $bits(rcbp_pkg::cmd_t) + QW;

  rcbp_pkg::cmd_t front_cmd;
  rcbp_pkg::cmd_t back_cmd;
  logic [QW-1:0]  front_quot;
  logic [QW-1:0]  back_quot;
  logic [CW-1:0]  q_head;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  rcbp_front #(
    .MAX_QUOTIENT(MAX_QUOTIENT),
    .QW          (QW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_op    (in_tuser),
    .in_value (in_tdata),
    .cmd      (front_cmd),
    .cmd_quot (front_quot)
  );

  rcbp_queue #(
    .WIDTH(CW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({front_quot, front_cmd}),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  assign back_cmd  = rcbp_pkg::cmd_t'(q_head[$bits(rcbp_pkg::cmd_t)-1:0]);
  assign back_quot = q_head[CW-1:$bits(rcbp_pkg::cmd_t)];

  rcbp_back #(
    .QW(QW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (back_cmd),
    .cmd_quot  (back_quot),
    .cmd_pop   (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == rcbp_pkg::KIND_ERROR) |-> (out_tlast && out_tdata == 8'd0))
    else $error("error result without last or with nonzero byte");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("outputs not cleared by reset");

endmodule
